### hdl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// Holds the depth, the action and status codes, the beat structs and the chain control.
// Depends on nothing.
`default_nettype none

package deq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT = 3'd2;
  localparam logic [2:0] ACT_POP_BACK = 3'd3;
  localparam logic [2:0] ACT_DUMP = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0] action;
    logic signed [DATA_W-1:0] value;
  } cmd_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] item;
    logic [1:0] status;
    logic last;
  } rsp_beat_t;

  typedef enum logic [2:0] {
    CH_HOLD,
    CH_PUSH_FRONT,
    CH_PUSH_BACK,
    CH_POP_FRONT,
    CH_ROTATE
  } chain_op_t;

  typedef struct packed {
    chain_op_t op;
    logic [CNT_W-1:0] count;
    logic signed [DATA_W-1:0] value;
  } chain_ctl_t;

endpackage

`default_nettype wire

### hdl/deq_cell.sv
// One storage cell of the queue chain.
// Keeps its element or picks its next one from its neighbors, the new value or the head cell.
// Depends on deq_pkg.
`default_nettype none

module deq_cell
  import deq_pkg::*;
(
  input  wire logic                     clk,
  input  wire chain_ctl_t               ctl,
  input  wire logic [IDX_W-1:0]         idx,
  input  wire logic signed [DATA_W-1:0] left,
  input  wire logic signed [DATA_W-1:0] right,
  input  wire logic signed [DATA_W-1:0] head,
  output logic signed [DATA_W-1:0]      data
);

  logic signed [DATA_W-1:0] data_next;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] tail;

  assign pos = CNT_W'(idx);
  assign tail = ctl.count - CNT_W'(1);

  always_comb begin
    data_next = data;
    case (ctl.op)
      CH_PUSH_FRONT: begin
        data_next = (pos == '0) ? ctl.value : left;
      end
      CH_PUSH_BACK: begin
        if (pos == ctl.count) begin
          data_next = ctl.value;
        end
      end
      CH_POP_FRONT: begin
        data_next = right;
      end
      CH_ROTATE: begin
        if (pos == tail) begin
          data_next = head;
        end else if (pos < tail) begin
          data_next = right;
        end
      end
      default: begin
        data_next = data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire

### hdl/double_ended_queue.sv
// Top level of the double-ended queue: a row of storage cells and its controller.
// Depends on deq_pkg and deq_cell.
//
//   port      dir  width  beat
//   start     in   1      command strobe, taken when busy is low
//   cmd       in   35     action and value
//   busy      out  1      high while a dump streams out
//   strobe    out  1      one result beat per cycle it is high
//   rsp       out  35     item, status and last
//
// A push, a pop or an error answer gives one registered result beat; it appears the next cycle.
// A dump of n elements gives n result beats back to back, the chain rotating
// one cell per cycle; busy is high while all but the last of them are shown.
// Reset empties the queue; there is no clearing pass.
// The receiver cannot stall, so every result leaves in the cycle it is shown.
`default_nettype none

module double_ended_queue
  import deq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  input  wire cmd_beat_t cmd,
  output logic           busy,
  output logic           strobe,
  output rsp_beat_t      rsp
);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  state_t state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] remaining;

  logic signed [DATA_W-1:0] cells [DEPTH];
  logic signed [DATA_W-1:0] back_item;
  logic [CNT_W-1:0] back_pos;
  logic accept;
  logic is_full;
  logic is_empty;
  chain_ctl_t ctl;

  assign busy = (state == S_DUMP);
  assign accept = start && !busy;
  assign is_full = (count == CNT_W'(DEPTH));
  assign is_empty = (count == '0);
  assign back_pos = count - CNT_W'(1);
  assign back_item = cells[back_pos[IDX_W-1:0]];

  always_comb begin
    ctl.op = CH_HOLD;
    ctl.count = count;
    ctl.value = cmd.value;
    if (state == S_DUMP) begin
      ctl.op = CH_ROTATE;
    end else if (accept) begin
      case (cmd.action)
        ACT_PUSH_FRONT: if (!is_full) ctl.op = CH_PUSH_FRONT;
        ACT_PUSH_BACK:  if (!is_full) ctl.op = CH_PUSH_BACK;
        ACT_POP_FRONT:  if (!is_empty) ctl.op = CH_POP_FRONT;
        ACT_DUMP:       if (!is_empty) ctl.op = CH_ROTATE;
        default:        ctl.op = CH_HOLD;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    deq_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .idx   (IDX_W'(i)),
      .left  ((i == 0) ? cells[0] : cells[(i + DEPTH - 1) % DEPTH]),
      .right ((i == DEPTH - 1) ? '0 : cells[(i + 1) % DEPTH]),
      .head  (cells[0]),
      .data  (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      remaining <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd.action)
              ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                strobe <= 1'b1;
                rsp <= '{item: '0, status: is_full ? ST_FULL : ST_OK, last: 1'b1};
                if (!is_full) begin
                  count <= count + CNT_W'(1);
                end
              end
              ACT_POP_FRONT, ACT_POP_BACK: begin
                strobe <= 1'b1;
                if (is_empty) begin
                  rsp <= '{item: '0, status: ST_EMPTY, last: 1'b1};
                end else begin
                  rsp <= '{item: (cmd.action == ACT_POP_FRONT) ? cells[0] : back_item,
                           status: ST_OK, last: 1'b1};
                  count <= count - CNT_W'(1);
                end
              end
              ACT_DUMP: begin
                strobe <= 1'b1;
                if (is_empty) begin
                  rsp <= '{item: '0, status: ST_EMPTY, last: 1'b1};
                end else begin
                  rsp <= '{item: cells[0], status: ST_OK, last: (count == CNT_W'(1))};
                  remaining <= count - CNT_W'(1);
                  if (count != CNT_W'(1)) begin
                    state <= S_DUMP;
                  end
                end
              end
              default: begin
                strobe <= 1'b0;
              end
            endcase
          end
        end
        S_DUMP: begin
          strobe <= 1'b1;
          rsp <= '{item: cells[0], status: ST_OK, last: (remaining == CNT_W'(1))};
          remaining <= remaining - CNT_W'(1);
          if (remaining == CNT_W'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_dump_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP |-> count != '0 && remaining != '0 && remaining < count)
    else $error("dump running with bad element count");

  a_error_item_zero: assert property (@(posedge clk) disable iff (rst)
    strobe && rsp.status != ST_OK |-> rsp.item == '0 && rsp.last)
    else $error("error beat carries data");

  a_dump_count_stable: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP |=> count == $past(count))
    else $error("occupancy changed during dump");

  a_dump_ends_last: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP && remaining == CNT_W'(1) |=> strobe && rsp.last && state == S_IDLE)
    else $error("dump did not end with a last beat");

endmodule

`default_nettype wire

### tb/tb_double_ended_queue.sv
// Self-checking testbench for the double-ended queue: directed and random command beats,
// with a local model of the ring store that predicts every result beat.
// Depends on deq_pkg and the double_ended_queue RTL.
`default_nettype none

module tb_double_ended_queue;
  import deq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 230;
  localparam int TAIL_CYCLES = 40;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] ACT_UNUSED_LO = ACT_DUMP + 3'd1;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_beat_t cmd = '0;
  logic busy;
  logic strobe;
  rsp_beat_t rsp;

  cmd_beat_t cmds_to_send[$];
  rsp_beat_t answers_due[$];

  logic signed [DATA_W-1:0] ring_copy[DEPTH];
  int head_pos = 0;
  int fill_count = 0;

  int burst_left = 1;
  int gap_left = 0;
  int fail_count = 0;
  int cycle_count = 0;

  double_ended_queue i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .strobe(strobe),
    .rsp(rsp)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Updates the local copy of the deque and queues the result beats that one command causes.
  task automatic apply_action(input cmd_beat_t c);
    rsp_beat_t r;
    int i;
    r = '0;
    r.last = 1'b1;
    case (c.action)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (fill_count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (c.action == ACT_PUSH_FRONT) begin
            head_pos = (head_pos + DEPTH - 1) % DEPTH;
            ring_copy[head_pos] = c.value;
          end else begin
            ring_copy[(head_pos + fill_count) % DEPTH] = c.value;
          end
          fill_count++;
          r.status = ST_OK;
        end
        answers_due.push_back(r);
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (fill_count == 0) begin
          r.status = ST_EMPTY;
        end else if (c.action == ACT_POP_FRONT) begin
          r.item = ring_copy[head_pos];
          head_pos = (head_pos + 1) % DEPTH;
          fill_count--;
        end else begin
          r.item = ring_copy[(head_pos + fill_count - 1) % DEPTH];
          fill_count--;
        end
        answers_due.push_back(r);
      end
      ACT_DUMP: begin
        if (fill_count == 0) begin
          r.status = ST_EMPTY;
          answers_due.push_back(r);
        end else begin
          for (i = 0; i < fill_count; i++) begin
            r.item = ring_copy[(head_pos + i) % DEPTH];
            r.status = ST_OK;
            r.last = (i == fill_count - 1);
            answers_due.push_back(r);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else if (!(start && busy)) begin
      if (start) begin
        apply_action(cmd);
        void'(cmds_to_send.pop_front());
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 12);
          gap_left = $urandom_range(1, 8);
        end
      end
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmds_to_send.size() == 0) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        cmd <= cmds_to_send[0];
      end
    end
  end

  always @(posedge clk) begin
    rsp_beat_t want;
    if (!rst && strobe) begin
      if (answers_due.size() == 0) begin
        $error("result beat with none expected: item %0d status %0d last %0b",
               rsp.item, rsp.status, rsp.last);
        fail_count++;
      end else begin
        want = answers_due.pop_front();
        if (rsp.item !== want.item) begin
          $error("item: expected %0d, actual %0d", want.item, rsp.item);
          fail_count++;
        end
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp.status);
          fail_count++;
        end
        if (rsp.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, rsp.last);
          fail_count++;
        end
      end
    end
  end

  task automatic queue_cmd(input logic [2:0] action, input logic signed [DATA_W-1:0] value);
    cmd_beat_t c;
    c.action = action;
    c.value = value;
    cmds_to_send.push_back(c);
  endtask

  task automatic wait_drained();
    while (cmds_to_send.size() != 0 || answers_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(DATA_W-1){1'b1}}};
      1: return {1'b1, {(DATA_W-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_push();
    return $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
  endfunction

  function automatic logic [2:0] pick_pop();
    return $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
  endfunction

  initial begin
    int counted;
    int mode;
    int len;
    int k;
    int roll;
    logic [2:0] act;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    queue_cmd(ACT_POP_FRONT, 32'sd5);
    queue_cmd(ACT_POP_BACK, -32'sd5);
    queue_cmd(ACT_DUMP, '0);
    queue_cmd(ACT_PUSH_BACK, {1'b0, {(DATA_W-1){1'b1}}});
    queue_cmd(ACT_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
    queue_cmd(ACT_PUSH_FRONT, '1);
    queue_cmd(ACT_DUMP, '0);
    queue_cmd(ACT_POP_BACK, '0);
    queue_cmd(ACT_POP_FRONT, '0);
    queue_cmd(ACT_POP_FRONT, '0);
    queue_cmd(ACT_DUMP, '0);
    queue_cmd(ACT_UNUSED_LO, 32'sd1);
    queue_cmd(ACT_UNUSED_LO + 3'd1, 32'sd2);
    queue_cmd(ACT_UNUSED_HI, 32'sd3);
    queue_cmd(ACT_PUSH_BACK, 32'sh5a5a_a5a5);
    queue_cmd(ACT_POP_FRONT, '0);
    queue_cmd(ACT_DUMP, '0);
    wait_drained();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(8, 20);
      for (k = 0; k < len; k++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          0: act = (roll < 90) ? pick_push() : ACT_DUMP;
          1: act = (roll < 90) ? pick_pop() : ACT_DUMP;
          default: begin
            if (roll < 40) act = pick_push();
            else if (roll < 75) act = pick_pop();
            else if (roll < 92) act = ACT_DUMP;
            else act = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
          end
        endcase
        queue_cmd(act, pick_value());
        if (act <= ACT_DUMP) counted++;
      end
      if (mode == 0) begin
        queue_cmd(ACT_DUMP, pick_value());
        counted++;
      end
      if ($urandom_range(0, 2) == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && answers_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
